@@ rtl/crc32_packet_framer_macros.svh @@
// Assertion macros shared by the framer RTL.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef CRC32_PACKET_FRAMER_MACROS_SVH
`define CRC32_PACKET_FRAMER_MACROS_SVH

`define CRCFR_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framer check failed");

`define CRCFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framer check failed");

`endif

@@ rtl/crcfr_pkg.sv @@
// Types, constants and the byte-wide CRC-32 update for the packet framer.
// No dependencies.
`default_nettype none
package crcfr_pkg;
	typedef logic [31:0] crc_t;
	typedef logic [3:0]  phase_t;

	localparam crc_t       CRC_POLY    = 32'h04C1_1DB7;
	localparam crc_t       CRC_INIT    = 32'hFFFF_FFFF;
	localparam logic [7:0] FILL_WAKE   = 8'h55;
	localparam logic [7:0] FILL_NORMAL = 8'hFF;
	localparam logic [7:0] HDR_ZERO    = 8'h00;

	// Output sequence positions of one request.
	localparam phase_t PH_HDR0  = 4'd0;
	localparam phase_t PH_HDR1  = 4'd1;
	localparam phase_t PH_FILL0 = 4'd2;
	localparam phase_t PH_FILL3 = 4'd5;
	localparam phase_t PH_DATA  = 4'd6;
	localparam phase_t PH_CRC0  = 4'd7;
	localparam phase_t PH_CRC1  = 4'd8;
	localparam phase_t PH_CRC2  = 4'd9;
	localparam phase_t PH_CRC3  = 4'd10;

	// MSB-first CRC-32 update over one byte.
	function automatic crc_t crc_byte(input crc_t crc, input logic [7:0] b);
		crc_t       c;
		logic [7:0] bs;
		logic       top;
		c  = crc;
		bs = b;
		for (int k = 0; k < 8; k++) begin
			top = c[31] ^ bs[7];
			c   = {c[30:0], 1'b0};
			if (top) begin
				c = c ^ CRC_POLY;
			end
			bs = {bs[6:0], 1'b0};
		end
		return c;
	endfunction
endpackage
`default_nettype wire

@@ rtl/crcfr_in_if.sv @@
// Input channel of the packet framer: payload byte requests.
// No dependencies.
`default_nettype none
interface crcfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;
	logic       wake_header;

	modport source (output valid, output payload_byte, output last_byte,
		output wake_header, input ready);
	modport sink (input valid, input payload_byte, input last_byte,
		input wake_header, output ready);
endinterface
`default_nettype wire

@@ rtl/crcfr_out_if.sv @@
// Output channel of the packet framer: framed wire bytes.
// No dependencies.
`default_nettype none
interface crcfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;
	logic       frame_end;

	modport source (output valid, output out_byte, output run_end,
		output frame_end, input ready);
	modport sink (input valid, input out_byte, input run_end,
		input frame_end, output ready);
endinterface
`default_nettype wire

@@ rtl/crc32_packet_framer.sv @@
// Top level of the CRC-32 packet framer.
// Depends on crcfr_pkg, crcfr_in_if, crcfr_out_if and crc32_packet_framer_macros.svh.
//
//  channel  | role  | payload
//  ---------+-------+------------------------------------------
//  in_ch    | sink  | payload_byte, last_byte, wake_header
//  out_ch   | source| out_byte, run_end, frame_end
//
// A request is registered with its updated CRC, then emitted one byte per cycle while
// out_ch is not stalled, through the output register: one byte mid-frame, plus 6 bytes
// when it opens a frame and plus 4 bytes when it closes one (at most 11 bytes).
// The next request is taken in the cycle the current one emits its final byte.
// Reset returns the CRC to all ones and closes any open frame.
// A stall on out_ch holds the output register and, once the holding stage is full,
// the input side.
`default_nettype none
`include "crc32_packet_framer_macros.svh"
module crc32_packet_framer (
	input  wire            clk,
	input  wire            arst_n,
	crcfr_in_if.sink       in_ch,
	crcfr_out_if.source    out_ch
);
	import crcfr_pkg::*;

	crc_t       crc_q;
	logic       in_frame_q;

	logic       valid_s1;
	phase_t     phase_s1;
	logic       hdr_s1;
	logic       last_s1;
	logic [7:0] fill_s1;
	logic [7:0] data_s1;
	crc_t       crc_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_end_q;
	logic       frame_end_q;

	logic       in_acc;
	logic       out_ld;
	logic       done;
	crc_t       crc_next;
	crc_t       crc_fin;
	logic [7:0] byte_sel;
	logic       run_sel;
	logic       end_sel;

	assign crc_next = crc_byte(in_frame_q ? crc_q : CRC_INIT, in_ch.payload_byte);
	assign crc_fin  = ~crc_s1;
	assign done     = (phase_s1 == PH_CRC3) || ((phase_s1 == PH_DATA) && !last_s1);
	assign out_ld   = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || (out_ld && done);
	assign in_acc   = in_ch.valid && in_ch.ready;

	always_comb begin
		byte_sel = HDR_ZERO;
		run_sel  = 1'b0;
		end_sel  = 1'b0;
		case (phase_s1) inside
			PH_HDR0, PH_HDR1: begin
				byte_sel = HDR_ZERO;
			end
			[PH_FILL0:PH_FILL3]: begin
				byte_sel = fill_s1;
			end
			PH_DATA: begin
				byte_sel = data_s1;
				run_sel  = !last_s1;
			end
			PH_CRC0: begin
				byte_sel = crc_fin[7:0];
			end
			PH_CRC1: begin
				byte_sel = crc_fin[15:8];
			end
			PH_CRC2: begin
				byte_sel = crc_fin[23:16];
			end
			PH_CRC3: begin
				byte_sel = crc_fin[31:24];
				run_sel  = 1'b1;
				end_sel  = 1'b1;
			end
			default: begin
				byte_sel = HDR_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			in_frame_q <= 1'b0;
		end else if (in_acc) begin
			if (in_ch.last_byte) begin
				crc_q      <= CRC_INIT;
				in_frame_q <= 1'b0;
			end else begin
				crc_q      <= crc_next;
				in_frame_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= PH_DATA;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			phase_s1 <= in_frame_q ? PH_DATA : PH_HDR0;
		end else if (out_ld) begin
			if (done) begin
				valid_s1 <= 1'b0;
			end
			phase_s1 <= phase_s1 + phase_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hdr_s1  <= !in_frame_q;
			last_s1 <= in_ch.last_byte;
			fill_s1 <= in_ch.wake_header ? FILL_WAKE : FILL_NORMAL;
			data_s1 <= in_ch.payload_byte;
			crc_s1  <= crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_byte_q  <= byte_sel;
			run_end_q   <= run_sel;
			frame_end_q <= end_sel;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_byte  = out_byte_q;
	assign out_ch.run_end   = run_end_q;
	assign out_ch.frame_end = frame_end_q;

	`CRCFR_ASSERT_SAME(a_take_only_when_done, in_acc && valid_s1, out_ld && done)
	`CRCFR_ASSERT_SAME(a_phase_range, valid_s1, phase_s1 <= PH_CRC3)
	`CRCFR_ASSERT_SAME(a_header_opens, valid_s1 && (phase_s1 < PH_DATA), hdr_s1)
	`CRCFR_ASSERT_NEXT(a_close_clears, in_acc && in_ch.last_byte, !in_frame_q && (crc_q == CRC_INIT))
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for crc32_packet_framer: payload byte requests go in,
// and every framed wire byte that comes out is checked against a built-in frame predictor.
// Depends on crcfr_pkg, crcfr_in_if, crcfr_out_if and the framer RTL.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import crcfr_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int PRESSURE_HOLD = 150;
	localparam int RANDOM_ITEMS  = 250;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       frame_end;
	} wire_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wire_byte_t wire_expect[$];
	crc_t       frame_crc;
	logic       frame_open;
	int         errors;
	int         idle_cycles;
	int         hold_cycles;
	int         stall_left;
	int         items_sent;
	bit         sink_stalls;
	bit         source_gaps;

	crcfr_in_if  in_ch();
	crcfr_out_if out_ch();

	crc32_packet_framer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#10ns clk = 1'b1;
		#10ns clk = 1'b0;
	end

	function automatic crc_t crc_shift_in(input crc_t c, input logic [7:0] b);
		crc_t r;
		r = c ^ {b, 24'h000000};
		for (int i = 0; i < 8; i++) begin
			r = r[31] ? ({r[30:0], 1'b0} ^ CRC_POLY) : {r[30:0], 1'b0};
		end
		return r;
	endfunction

	function automatic void predict_wire_bytes(input logic [7:0] b, input logic last,
		input logic wake);
		crc_t       fin;
		logic [7:0] fill;
		if (!frame_open) begin
			fill = wake ? FILL_WAKE : FILL_NORMAL;
			frame_crc = CRC_INIT;
			frame_open = 1'b1;
			wire_expect.push_back({HDR_ZERO, 1'b0, 1'b0});
			wire_expect.push_back({HDR_ZERO, 1'b0, 1'b0});
			repeat (4) wire_expect.push_back({fill, 1'b0, 1'b0});
		end
		frame_crc = crc_shift_in(frame_crc, b);
		wire_expect.push_back({b, !last, 1'b0});
		if (last) begin
			fin = ~frame_crc;
			for (int k = 0; k < 4; k++) begin
				wire_expect.push_back({fin[8*k +: 8], k == 3, k == 3});
			end
			frame_crc = CRC_INIT;
			frame_open = 1'b0;
		end
	endfunction

	function automatic int frame_length();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) begin
			return 1;
		end else if (r < 9) begin
			return $urandom_range(2, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	task automatic source_gap();
		int r;
		int gap;
		r = $urandom_range(0, 9);
		gap = 0;
		if (source_gaps) begin
			if (r >= 9) begin
				gap = $urandom_range(10, 40);
			end else if (r >= 5) begin
				gap = $urandom_range(1, 3);
			end
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_request(input logic [7:0] b, input logic last, input logic wake);
		in_ch.valid <= 1'b1;
		in_ch.payload_byte <= b;
		in_ch.last_byte <= last;
		in_ch.wake_header <= wake;
		do @(posedge clk); while (!in_ch.ready);
		predict_wire_bytes(b, last, wake);
		items_sent++;
		source_gap();
	endtask

	task automatic send_frame(input int len, input logic wake_first);
		for (int i = 0; i < len; i++) begin
			send_request(8'($urandom_range(0, 255)), i == len - 1,
				(i == 0) ? wake_first : logic'($urandom_range(0, 1)));
		end
	endtask

	task automatic source_idle();
		in_ch.valid <= 1'b0;
		while (wire_expect.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_frames();
		logic [7:0] check_str[9];
		check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
		sink_stalls = 1'b0;
		source_gaps = 1'b0;
		send_request(8'h00, 1'b1, 1'b1);
		send_request(8'hFF, 1'b1, 1'b0);
		send_request(8'hFF, 1'b1, 1'b1);
		// The fill is chosen by the opening request only.
		send_request(8'h80, 1'b0, 1'b0);
		send_request(8'h01, 1'b0, 1'b1);
		send_request(8'h7F, 1'b0, 1'b0);
		send_request(8'hAA, 1'b0, 1'b1);
		send_request(8'h55, 1'b1, 1'b1);
		for (int i = 0; i < 9; i++) begin
			send_request(check_str[i], i == 8, 1'b1);
		end
		source_idle();
	endtask

	task automatic test_output_backpressure();
		sink_stalls = 1'b0;
		source_gaps = 1'b0;
		hold_cycles = PRESSURE_HOLD;
		for (int f = 0; f < 4; f++) begin
			send_frame($urandom_range(3, 8), logic'($urandom_range(0, 1)));
		end
		source_idle();
		hold_cycles = PRESSURE_HOLD;
		repeat (8) send_frame(1, logic'($urandom_range(0, 1)));
		source_idle();
	endtask

	task automatic test_random_frames();
		int goal;
		goal = items_sent + RANDOM_ITEMS;
		sink_stalls = 1'b1;
		source_gaps = 1'b1;
		while (items_sent < goal) begin
			if ($urandom_range(0, 7) == 0) begin
				source_gaps = !source_gaps;
			end
			if ($urandom_range(0, 7) == 0) begin
				sink_stalls = !sink_stalls;
			end
			send_frame(frame_length(), logic'($urandom_range(0, 1)));
		end
		source_idle();
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_ch.ready <= 1'b0;
		end else if (!sink_stalls) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) :
				$urandom_range(0, 2);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_output
		wire_byte_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (wire_expect.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte %h run_end %b frame_end %b", $time,
					out_ch.out_byte, out_ch.run_end, out_ch.frame_end);
			end else begin
				want = wire_expect.pop_front();
				if (out_ch.out_byte !== want.data) begin
					errors++;
					$display("%0t: out_byte expected %h actual %h", $time, want.data,
						out_ch.out_byte);
				end
				if (out_ch.run_end !== want.run_end) begin
					errors++;
					$display("%0t: run_end expected %b actual %b", $time, want.run_end,
						out_ch.run_end);
				end
				if (out_ch.frame_end !== want.frame_end) begin
					errors++;
					$display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
						out_ch.frame_end);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.payload_byte = 8'h00;
		in_ch.last_byte = 1'b0;
		in_ch.wake_header = 1'b0;
		out_ch.ready = 1'b0;
		frame_crc = CRC_INIT;
		frame_open = 1'b0;
		errors = 0;
		idle_cycles = 0;
		hold_cycles = 0;
		stall_left = 0;
		items_sent = 0;
		sink_stalls = 1'b0;
		source_gaps = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_output_backpressure();
		test_random_frames();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && wire_expect.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/crcfr_pkg.sv
rtl/crcfr_in_if.sv
rtl/crcfr_out_if.sv
rtl/crc32_packet_framer.sv
verif/tb_top.sv
